### design/ctt_pkg.sv
// Shared types and constants for the comment-aware text tokenizer.
// Holds the transfer payload structs, the per-item result bundle and character codes.
// No dependencies.
package ctt_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 3;
    localparam int RES_IDX_W   = 2;

    localparam logic [1:0] CMD_BYTE       = 2'd0;
    localparam logic [1:0] CMD_BYTE_FLUSH = 2'd1;
    localparam logic [1:0] CMD_FLUSH      = 2'd2;
    localparam logic [1:0] CMD_FLUSH_ALT  = 2'd3;

    localparam logic [2:0] MODE_DEFAULT    = 3'd0;
    localparam logic [2:0] MODE_STRING     = 3'd1;
    localparam logic [2:0] MODE_SLASH      = 3'd2;
    localparam logic [2:0] MODE_LINE       = 3'd3;
    localparam logic [2:0] MODE_BLOCK      = 3'd4;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd5;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_SINGLE = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_in;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic       last_in_run;
    } result_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
    } token_t;

    typedef struct packed {
        logic [RES_IDX_W-1:0]         count;
        token_t [MAX_RESULTS-1:0]     tokens;
    } bundle_t;

endpackage

### design/comment_aware_text_tokenizer_core.sv
// Comment-aware text tokenizer, top level. Accepts one item per cycle while the
// bundle queue has room; with nothing ahead, an item's bundle is written into the queue
// and then into the output register. Output is one token per cycle while result_ready
// is high, so three-token items drain slowly; QUEUE_DEPTH bundles absorb it.
// Reset clears lexer mode, quote byte, open-token flag, queue and output stage.
// Depends on ctt_pkg, ctt_front, ctt_queue and ctt_back.
module comment_aware_text_tokenizer_core
#(
    parameter int QUEUE_DEPTH = ctt_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ctt_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ctt_pkg::result_t result
);

    logic             push_valid;
    logic             push_ready;
    ctt_pkg::bundle_t push_data;
    logic             pop_valid;
    logic             pop_ready;
    ctt_pkg::bundle_t pop_data;

    ctt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ctt_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ctt_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### design/ctt_front.sv
// Front end of the tokenizer: accepts input items, tracks lexer state and
// builds one bundle of up to three tokens per item. Depends on ctt_pkg.
module ctt_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  ctt_pkg::item_t  item,
    output logic            push_valid,
    input  logic            push_ready,
    output ctt_pkg::bundle_t push_data
);

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [7:0] quote_reg;
    logic [7:0] quote_next;
    logic       token_open_reg;
    logic       token_open_next;
    logic       accept;

    ctt_pkg::bundle_t bundle;

    function automatic ctt_pkg::bundle_t push_token(ctt_pkg::bundle_t b, logic [1:0] kind,
                                                    logic [7:0] ch);
        ctt_pkg::bundle_t r;
        r = b;
        if (b.count < ctt_pkg::RES_IDX_W'(ctt_pkg::MAX_RESULTS))
        begin
            r.tokens[b.count].kind     = kind;
            r.tokens[b.count].char_out = ch;
            r.count                    = b.count + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        logic [7:0] ch;
        logic       tok;
        ch         = item.char_in;
        tok        = token_open_reg;
        bundle     = '0;
        mode_next  = mode_reg;
        quote_next = quote_reg;
        if (!item.command[1])
        begin
            unique case (mode_reg)
                ctt_pkg::MODE_DEFAULT:
                begin
                    priority if (ch == ctt_pkg::CH_SPACE || ch == ctt_pkg::CH_TAB ||
                                 ch == ctt_pkg::CH_COMMA)
                    begin
                        if (tok)
                        begin
                            bundle = push_token(bundle, ctt_pkg::KIND_END, 8'h00);
                            tok    = 1'b0;
                        end
                    end
                    else if (ch == ctt_pkg::CH_NEWLINE || ch == ctt_pkg::CH_LBRACK ||
                             ch == ctt_pkg::CH_RBRACK)
                    begin
                        if (tok)
                        begin
                            bundle = push_token(bundle, ctt_pkg::KIND_END, 8'h00);
                            tok    = 1'b0;
                        end
                        bundle = push_token(bundle, ctt_pkg::KIND_SINGLE, ch);
                    end
                    else if (ch == ctt_pkg::CH_DQUOTE || ch == ctt_pkg::CH_SQUOTE)
                    begin
                        if (tok)
                        begin
                            bundle = push_token(bundle, ctt_pkg::KIND_END, 8'h00);
                        end
                        bundle     = push_token(bundle, ctt_pkg::KIND_CHAR, ch);
                        tok        = 1'b1;
                        quote_next = ch;
                        mode_next  = ctt_pkg::MODE_STRING;
                    end
                    else if (ch == ctt_pkg::CH_SLASH)
                    begin
                        if (tok)
                        begin
                            bundle = push_token(bundle, ctt_pkg::KIND_END, 8'h00);
                            tok    = 1'b0;
                        end
                        mode_next = ctt_pkg::MODE_SLASH;
                    end
                    else
                    begin
                        bundle = push_token(bundle, ctt_pkg::KIND_CHAR, ch);
                        tok    = 1'b1;
                    end
                end
                ctt_pkg::MODE_STRING:
                begin
                    bundle = push_token(bundle, ctt_pkg::KIND_CHAR, ch);
                    tok    = 1'b1;
                    if (ch == quote_reg)
                    begin
                        mode_next = ctt_pkg::MODE_DEFAULT;
                        bundle    = push_token(bundle, ctt_pkg::KIND_END, 8'h00);
                        tok       = 1'b0;
                    end
                end
                ctt_pkg::MODE_SLASH:
                begin
                    priority if (ch == ctt_pkg::CH_SLASH)
                    begin
                        mode_next = ctt_pkg::MODE_LINE;
                    end
                    else if (ch == ctt_pkg::CH_STAR)
                    begin
                        mode_next = ctt_pkg::MODE_BLOCK;
                    end
                    else
                    begin
                        if (ch == ctt_pkg::CH_NEWLINE)
                        begin
                            bundle = push_token(bundle, ctt_pkg::KIND_SINGLE, ch);
                        end
                        mode_next = ctt_pkg::MODE_DEFAULT;
                    end
                end
                ctt_pkg::MODE_LINE:
                begin
                    if (ch == ctt_pkg::CH_NEWLINE)
                    begin
                        bundle    = push_token(bundle, ctt_pkg::KIND_SINGLE, ch);
                        mode_next = ctt_pkg::MODE_DEFAULT;
                    end
                end
                ctt_pkg::MODE_BLOCK:
                begin
                    priority if (ch == ctt_pkg::CH_STAR)
                    begin
                        mode_next = ctt_pkg::MODE_BLOCK_STAR;
                    end
                    else if (ch == ctt_pkg::CH_NEWLINE)
                    begin
                        bundle = push_token(bundle, ctt_pkg::KIND_SINGLE, ch);
                    end
                    else
                    begin
                        mode_next = mode_reg;
                    end
                end
                ctt_pkg::MODE_BLOCK_STAR:
                begin
                    if (ch == ctt_pkg::CH_SLASH)
                    begin
                        mode_next = ctt_pkg::MODE_DEFAULT;
                    end
                    else
                    begin
                        if (ch == ctt_pkg::CH_NEWLINE)
                        begin
                            bundle = push_token(bundle, ctt_pkg::KIND_SINGLE, ch);
                        end
                        mode_next = ctt_pkg::MODE_BLOCK;
                    end
                end
                default:
                begin
                    mode_next = ctt_pkg::MODE_DEFAULT;
                end
            endcase
        end
        if (item.command != ctt_pkg::CMD_BYTE && tok)
        begin
            bundle = push_token(bundle, ctt_pkg::KIND_END, 8'h00);
            tok    = 1'b0;
        end
        token_open_next = tok;
    end

    assign item_ready = push_ready;
    assign accept     = item_valid && item_ready;
    assign push_valid = item_valid && (bundle.count != '0);
    assign push_data  = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ctt_pkg::MODE_DEFAULT;
            quote_reg      <= 8'h00;
            token_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            quote_reg      <= quote_next;
            token_open_reg <= token_open_next;
        end
    end

endmodule

### design/ctt_queue.sv
// Bundle queue between the tokenizer front end and the output sequencer.
// Small register-array FIFO of result bundles. Depends on ctt_pkg.
module ctt_queue
#(
    parameter int DEPTH = ctt_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ctt_pkg::bundle_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ctt_pkg::bundle_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ctt_pkg::bundle_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/ctt_back.sv
// Output sequencer of the tokenizer: holds one bundle in a register and transfers
// its tokens one per cycle while result_ready is high, marking the last. Depends on ctt_pkg.
module ctt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  ctt_pkg::bundle_t pop_data,
    output logic             result_valid,
    input  logic             result_ready,
    output ctt_pkg::result_t result
);

    ctt_pkg::bundle_t              head_reg;
    logic                          head_valid_reg;
    logic                          head_valid_next;
    logic [ctt_pkg::RES_IDX_W-1:0] idx_reg;
    logic [ctt_pkg::RES_IDX_W-1:0] idx_next;
    logic                          is_last;
    logic                          out_fire;
    logic                          load;

    assign is_last      = (idx_reg == head_reg.count - 1'b1);
    assign result_valid = head_valid_reg;
    assign out_fire     = result_valid && result_ready;
    assign load         = pop_valid && (!head_valid_reg || (out_fire && is_last));
    assign pop_ready    = load;

    always_comb
    begin
        result.kind        = head_reg.tokens[idx_reg].kind;
        result.char_out    = head_reg.tokens[idx_reg].char_out;
        result.last_in_run = is_last;
    end

    always_comb
    begin
        head_valid_next = head_valid_reg;
        idx_next        = idx_reg;
        priority if (load)
        begin
            head_valid_next = 1'b1;
            idx_next        = '0;
        end
        else if (out_fire && is_last)
        begin
            head_valid_next = 1'b0;
        end
        else if (out_fire)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            head_reg <= pop_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            idx_reg        <= idx_next;
        end
    end

endmodule
